@@ design/laq_pkg.sv @@
// Shared types, codes and field widths for the level ancestor query block.
package laq_pkg;

  // Field widths fixed by the item format.
  localparam int LABEL_W  = 6;
  localparam int DEPTH_W  = 6;
  localparam int DIST_W   = 6;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // One label-indexed and one level-indexed entry per code of a 6-bit field.
  localparam int LABELS = 1 << LABEL_W;
  localparam int LEVELS = 1 << DEPTH_W;

  // Default node capacity.
  localparam int DEF_MAX_NODES = 64;

  // Stream word widths, padded to whole bytes.
  localparam int IN_BITS  = ACTION_W + LABEL_W + DEPTH_W + DIST_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = LABEL_W + STATUS_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_ANC  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QLBL,
    ST_QCNT,
    ST_QSRCH,
    ST_QEND,
    ST_QFOUND,
    ST_QNODE,
    ST_DONE
  } state_t;

endpackage

@@ design/level_ancestor_query.sv @@
// Top level of the level ancestor query block.
// A word either clears the tree, loads the next node of a preorder walk, or asks for the
// ancestor a given number of levels above a node; every word gives exactly one result word.
// Per-label depth and preorder number, the label at each preorder number, the count of each
// level and each level's preorder list sit in synchronous memories with registered reads.
// A query runs a binary search over the preorder list of the target level; a level of n
// entries needs at most floor(log2(n)) + 1 steps. The query time is set by the binary
// search, one dependent read of the level list memory per step. A result waits while the
// output register is still full. One word is worked on at a time; a new word is taken while
// a result still waits on the output. Up to MAX_NODES nodes are held between clears;
// further loads report full.
module level_ancestor_query #(
  parameter int MAX_NODES = laq_pkg::DEF_MAX_NODES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // action [1:0], node_label [7:2], node_depth [13:8], query_distance [19:14], zero pad
  input  logic [laq_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // ancestor_label [5:0], status [7:6]
  output logic [laq_pkg::OUT_W-1:0] m_tdata
);

  localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW = $clog2(MAX_NODES + 1);
  localparam int AW = laq_pkg::DEPTH_W + SW;
  localparam int LW = laq_pkg::LABEL_W;
  localparam int DW = laq_pkg::DEPTH_W;

  laq_pkg::state_t state, state_next;

  // Input word fields.
  logic [laq_pkg::ACTION_W-1:0] in_action;
  logic [LW-1:0]                in_label;
  logic [DW-1:0]                in_depth;
  logic [laq_pkg::DIST_W-1:0]   in_dist;
  logic                         accept;

  assign in_action = s_tdata[1:0];
  assign in_label  = s_tdata[7:2];
  assign in_depth  = s_tdata[13:8];
  assign in_dist   = s_tdata[19:14];
  assign s_tready  = (state == laq_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Working registers.
  logic [PW-1:0]                node_cnt;
  logic [LW-1:0]                it_label;
  logic [DW-1:0]                it_depth;
  logic [laq_pkg::DIST_W-1:0]   it_dist;
  logic [PW-1:0]                key;
  logic [DW-1:0]                lvl;
  logic [PW-1:0]                lo;
  logic [PW-1:0]                hi;
  logic [LW-1:0]                res_label;
  logic [laq_pkg::STATUS_W-1:0] res_status;

  // Memory interfaces.
  logic [DW+PW-1:0]  label_mem [laq_pkg::LABELS];
  logic [DW+PW-1:0]  label_rd;
  logic [LW-1:0]     label_raddr;
  logic              label_we;
  logic [LW-1:0]     node_mem [MAX_NODES];
  logic [LW-1:0]     node_rd;
  logic [SW-1:0]     node_raddr;
  logic              node_we;
  logic              clr_levels;
  logic [DW-1:0]     cnt_raddr;
  logic [PW-1:0]     cnt_rdata;
  logic              cnt_we;
  logic [AW-1:0]     st_raddr;
  logic [PW-1:0]     st_rdata;
  logic              st_we;

  // Fields of the label memory read.
  logic [DW-1:0]     own_depth;
  logic [PW-1:0]     own_pre;
  assign own_depth = label_rd[DW+PW-1:PW];
  assign own_pre   = label_rd[PW-1:0];

  // Search step: probe at the midpoint, then narrow the window.
  logic [PW:0]       sum_cur;
  logic [PW-1:0]     mid_cur;
  logic              go_right;
  logic [PW-1:0]     srch_lo;
  logic [PW-1:0]     srch_hi;
  logic [PW:0]       sum_next;
  logic [PW-1:0]     cnt_half;
  logic [PW-1:0]     lo_dec;
  logic [PW-1:0]     found_dec;
  logic              found_bad;
  logic              full;
  logic              out_free;

  assign sum_cur   = {1'b0, lo} + {1'b0, hi};
  assign mid_cur   = sum_cur[PW:1];
  assign go_right  = (st_rdata < key);
  assign srch_lo   = go_right ? (mid_cur + PW'(1)) : lo;
  assign srch_hi   = go_right ? hi : mid_cur;
  assign sum_next  = {1'b0, srch_lo} + {1'b0, srch_hi};
  assign cnt_half  = cnt_rdata >> 1;
  assign lo_dec    = lo - PW'(1);
  assign found_dec = st_rdata - PW'(1);
  assign found_bad = (st_rdata == '0) || (st_rdata > PW'(MAX_NODES));
  assign full      = (node_cnt == PW'(MAX_NODES));
  assign out_free  = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      laq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == laq_pkg::ACT_LOAD && !full) begin
            state_next = laq_pkg::ST_LOAD;
          end else if (in_action == laq_pkg::ACT_QUERY && in_dist != '0) begin
            state_next = laq_pkg::ST_QLBL;
          end else begin
            state_next = laq_pkg::ST_DONE;
          end
        end
      end
      laq_pkg::ST_LOAD: begin
        state_next = laq_pkg::ST_DONE;
      end
      laq_pkg::ST_QLBL: begin
        state_next = (it_dist > own_depth) ? laq_pkg::ST_DONE : laq_pkg::ST_QCNT;
      end
      laq_pkg::ST_QCNT: begin
        state_next = (cnt_rdata != '0) ? laq_pkg::ST_QSRCH : laq_pkg::ST_QEND;
      end
      laq_pkg::ST_QSRCH: begin
        state_next = (srch_lo < srch_hi) ? laq_pkg::ST_QSRCH : laq_pkg::ST_QEND;
      end
      laq_pkg::ST_QEND: begin
        state_next = (lo == '0) ? laq_pkg::ST_DONE : laq_pkg::ST_QFOUND;
      end
      laq_pkg::ST_QFOUND: begin
        state_next = found_bad ? laq_pkg::ST_DONE : laq_pkg::ST_QNODE;
      end
      laq_pkg::ST_QNODE: begin
        state_next = laq_pkg::ST_DONE;
      end
      laq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = laq_pkg::ST_IDLE;
        end
      end
      default: state_next = laq_pkg::ST_IDLE;
    endcase
  end

  // Memory controls for each state.
  always_comb begin
    label_raddr = in_label;
    label_we    = 1'b0;
    node_we     = 1'b0;
    node_raddr  = found_dec[SW-1:0];
    clr_levels  = 1'b0;
    cnt_raddr   = in_depth;
    cnt_we      = 1'b0;
    st_raddr    = {lvl, lo_dec[SW-1:0]};
    st_we       = 1'b0;
    unique case (state)
      laq_pkg::ST_IDLE: begin
        clr_levels = accept && (in_action == laq_pkg::ACT_CLEAR);
      end
      laq_pkg::ST_LOAD: begin
        label_we = 1'b1;
        node_we  = 1'b1;
        cnt_we   = 1'b1;
        st_we    = 1'b1;
      end
      laq_pkg::ST_QLBL: begin
        cnt_raddr = own_depth - it_dist;
      end
      laq_pkg::ST_QCNT: begin
        st_raddr = {lvl, cnt_half[SW-1:0]};
      end
      laq_pkg::ST_QSRCH: begin
        st_raddr = {lvl, sum_next[SW:1]};
      end
      laq_pkg::ST_QEND,
      laq_pkg::ST_QFOUND,
      laq_pkg::ST_QNODE,
      laq_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= laq_pkg::ST_IDLE;
      node_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_levels) begin
        node_cnt <= '0;
      end else if (state == laq_pkg::ST_LOAD) begin
        node_cnt <= node_cnt + PW'(1);
      end
      if (state == laq_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item, search window and result registers.
  always_ff @(posedge clk) begin
    case (state)
      laq_pkg::ST_IDLE: begin
        it_label   <= in_label;
        it_depth   <= in_depth;
        it_dist    <= in_dist;
        res_label  <= '0;
        res_status <= laq_pkg::STS_OK;
        if (in_action == laq_pkg::ACT_LOAD && full) begin
          res_status <= laq_pkg::STS_FULL;
        end else if (in_action == laq_pkg::ACT_QUERY && in_dist == '0) begin
          res_label <= in_label;
        end
      end
      laq_pkg::ST_QLBL: begin
        key <= own_pre;
        lvl <= own_depth - it_dist;
        if (it_dist > own_depth) begin
          res_status <= laq_pkg::STS_NO_ANC;
        end
      end
      laq_pkg::ST_QCNT: begin
        lo <= '0;
        hi <= cnt_rdata;
      end
      laq_pkg::ST_QSRCH: begin
        lo <= srch_lo;
        hi <= srch_hi;
      end
      laq_pkg::ST_QEND: begin
        if (lo == '0) begin
          res_status <= laq_pkg::STS_NO_ANC;
        end
      end
      laq_pkg::ST_QFOUND: begin
        if (found_bad) begin
          res_status <= laq_pkg::STS_NO_ANC;
        end
      end
      laq_pkg::ST_QNODE: begin
        res_label <= node_rd;
      end
      default: begin
      end
    endcase
    if (state == laq_pkg::ST_DONE && out_free) begin
      m_tdata <= {{(laq_pkg::OUT_W - laq_pkg::OUT_BITS){1'b0}}, res_status, res_label};
    end
  end

  // Per-label depth and preorder number.
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[it_label] <= {it_depth, node_cnt + PW'(1)};
    end
    label_rd <= label_mem[label_raddr];
  end

  // Label at each preorder number, stored one below the number.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_cnt[SW-1:0]] <= it_label;
    end
    node_rd <= node_mem[node_raddr];
  end

  // Level counts and level lists.
  laq_level_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_level_mem (
    .clk        (clk),
    .rst        (rst),
    .clr_levels (clr_levels),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata),
    .cnt_we     (cnt_we),
    .cnt_waddr  (it_depth),
    .cnt_wdata  (cnt_rdata + PW'(1)),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata),
    .st_we      (st_we),
    .st_waddr   ({it_depth, cnt_rdata[SW-1:0]}),
    .st_wdata   (node_cnt + PW'(1))
  );

endmodule

@@ design/laq_level_mem.sv @@
// Per-level entry counts with valid bits and the per-level preorder lists.
module laq_level_mem #(
  parameter int MAX_NODES = laq_pkg::DEF_MAX_NODES,
  localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int PW = $clog2(MAX_NODES + 1),
  localparam int AW = laq_pkg::DEPTH_W + SW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr_levels,
  input  logic [laq_pkg::DEPTH_W-1:0] cnt_raddr,
  output logic [PW-1:0]               cnt_rdata,
  input  logic                        cnt_we,
  input  logic [laq_pkg::DEPTH_W-1:0] cnt_waddr,
  input  logic [PW-1:0]               cnt_wdata,
  input  logic [AW-1:0]               st_raddr,
  output logic [PW-1:0]               st_rdata,
  input  logic                        st_we,
  input  logic [AW-1:0]               st_waddr,
  input  logic [PW-1:0]               st_wdata
);

  logic [PW-1:0]                 cnt_mem [laq_pkg::LEVELS];
  logic [laq_pkg::LEVELS-1:0]    cnt_valid;
  logic [PW-1:0]                 cnt_raw;
  logic                          cnt_hit;
  logic [PW-1:0]                 st_mem [laq_pkg::LEVELS * (1 << SW)];

  // Valid bits make every level read as empty after reset or a clear.
  always_ff @(posedge clk) begin
    if (rst || clr_levels) begin
      cnt_valid <= '0;
    end else if (cnt_we) begin
      cnt_valid[cnt_waddr] <= 1'b1;
    end
  end

  // Count memory with a registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_raw <= cnt_mem[cnt_raddr];
    cnt_hit <= cnt_valid[cnt_raddr];
  end

  assign cnt_rdata = cnt_hit ? cnt_raw : '0;

  // Level list memory, addressed by level and slot.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata <= st_mem[st_raddr];
  end

endmodule
